### rtl/core/indexed_ordered_list_unit_macros.svh
// assertion macros for the indexed ordered list unit
`ifndef INDEXED_ORDERED_LIST_UNIT_MACROS_SVH
`define INDEXED_ORDERED_LIST_UNIT_MACROS_SVH

// condition holds at every clock edge out of reset
`define IOLU_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define IOLU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define IOLU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/iolu_pkg.sv
// shared types, codes and constants of the indexed ordered list unit
package iolu_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    localparam int CMD_W     = 3;
    localparam int POS_W     = 5;
    localparam int VALUE_W   = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 5;

    localparam logic [CMD_W-1:0] CMD_ADD_FIRST    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_LAST     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_FIRST = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE_LAST  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE       = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SET          = 3'd6;
    localparam logic [CMD_W-1:0] CMD_GET          = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

    // slot selection for index loads
    localparam logic [1:0] K_ZERO     = 2'd0;
    localparam logic [1:0] K_COUNT    = 2'd1;
    localparam logic [1:0] K_COUNT_M1 = 2'd2;
    localparam logic [1:0] K_POS_M1   = 2'd3;

    // read address selection
    localparam logic [1:0] RD_IDX    = 2'd0;
    localparam logic [1:0] RD_IDX_M1 = 2'd1;
    localparam logic [1:0] RD_IDX_P1 = 2'd2;

    // write data selection
    localparam logic WR_RDATA = 1'b0;
    localparam logic WR_VALUE = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [VALUE_W-1:0]   data_out;
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty_flag;
    } t_out_word;

    typedef struct packed {
        logic              load_in;
        logic              res_clr;
        logic              set_status;
        logic [STAT_W-1:0] status;
        logic              idx_load;
        logic              ins_load;
        logic [1:0]        k_sel;
        logic              idx_inc;
        logic              idx_dec;
        logic              rd_en;
        logic [1:0]        rd_sel;
        logic              wr_en;
        logic              wr_sel;
        logic              cap;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              res_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             pos_ok;
        logic             ins_ok;
        logic             idx_gt_end;
        logic             rm_more;
        logic             out_busy;
    } t_dp_stat;

endpackage

### rtl/core/indexed_ordered_list_unit.sv
// top level of the indexed ordered list unit
// Bounded ordered list of up to DEPTH values with 1-based positions, one command word in and
// one result word out. Entries live in a single-port-read, single-port-write memory, so every
// shift moves one entry at a time, a read followed by a write. A rejected command goes
// straight to the result; an add, insert or remove shifts at most DEPTH - 1 entries.
// The result register lets the next command be accepted while the previous result waits.
// No clearing pass runs after reset.
module indexed_ordered_list_unit #(
    parameter int DEPTH  = iolu_pkg::DEPTH_DEF,
    parameter int DATA_W = iolu_pkg::DATA_W_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  iolu_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output iolu_pkg::t_out_word o_out_word
);
    import iolu_pkg::*;

    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;

    iolu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    iolu_dpath #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

### rtl/core/iolu_dpath.sv
// datapath: entry memory, count, index registers and result register
module iolu_dpath #(
    parameter int DEPTH  = iolu_pkg::DEPTH_DEF,
    parameter int DATA_W = iolu_pkg::DATA_W_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iolu_pkg::t_in_word  i_in_word,
    input  iolu_pkg::t_ctl_cmd  i_cmd,
    input  logic                i_out_ready,
    output iolu_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    output iolu_pkg::t_out_word o_out_word
);
    import iolu_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [DATA_W-1:0] r_mem [DEPTH];

    logic [CMD_W-1:0]  r_cmd;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_val;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_end;
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_res_data;
    logic [STAT_W-1:0] r_res_status;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic [CMP_W-1:0]  w_pos_ext;
    logic [CMP_W-1:0]  w_cnt_ext;
    logic [CMP_W-1:0]  w_pos_m1;
    logic [CNT_W-1:0]  w_cnt_m1;
    logic [CNT_W-1:0]  w_idx_p1;
    logic [IDX_W-1:0]  w_k;
    logic [IDX_W-1:0]  w_rd_addr;
    logic [DATA_W-1:0] w_wr_data;

    assign w_pos_ext = CMP_W'(r_pos);
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_pos_m1  = w_pos_ext - CMP_W'(1);
    assign w_cnt_m1  = r_count - CNT_W'(1);
    assign w_idx_p1  = CNT_W'(r_idx) + CNT_W'(1);

    always_comb begin
        unique case (i_cmd.k_sel)
            K_ZERO:     w_k = '0;
            K_COUNT:    w_k = r_count[IDX_W-1:0];
            K_COUNT_M1: w_k = w_cnt_m1[IDX_W-1:0];
            K_POS_M1:   w_k = w_pos_m1[IDX_W-1:0];
            default:    w_k = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_IDX:    w_rd_addr = r_idx;
            RD_IDX_M1: w_rd_addr = r_idx - IDX_W'(1);
            RD_IDX_P1: w_rd_addr = w_idx_p1[IDX_W-1:0];
            default:   w_rd_addr = r_idx;
        endcase
    end

    assign w_wr_data = (i_cmd.wr_sel == WR_VALUE) ? r_val : r_rdata;

    assign o_stat.cmd        = r_cmd;
    assign o_stat.full       = (r_count >= CNT_W'(DEPTH));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.pos_ok     = (r_pos != '0) && (w_pos_ext <= w_cnt_ext);
    assign o_stat.ins_ok     = (r_pos != '0) && (w_pos_ext <= (w_cnt_ext + CMP_W'(1)));
    assign o_stat.idx_gt_end = (r_idx > r_end);
    assign o_stat.rm_more    = (w_idx_p1 < r_count);
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    // entry memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
        if (i_cmd.wr_en) begin
            r_mem[r_idx] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= i_in_word.command;
            r_pos <= i_in_word.position;
            r_val <= DATA_W'(i_in_word.value);
        end
        if (i_cmd.idx_load) begin
            r_idx <= w_k;
        end else if (i_cmd.ins_load) begin
            r_idx <= r_count[IDX_W-1:0];
            r_end <= w_k;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - IDX_W'(1);
        end
        if (i_cmd.res_clr) begin
            r_res_data <= '0;
        end else if (i_cmd.cap) begin
            r_res_data <= r_rdata;
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.res_load) begin
            r_out_word.data_out   <= VALUE_W'(r_res_data);
            r_out_word.status     <= r_res_status;
            r_out_word.count      <= CNT_OUT_W'(r_count);
            r_out_word.empty_flag <= (r_count == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### rtl/core/iolu_ctrl.sv
// controller: command decode, checks and shift sequencing
module iolu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  iolu_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output iolu_pkg::t_ctl_cmd o_cmd
);
    import iolu_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_RD_AT  = 4'd2;
    localparam logic [3:0] S_CAP    = 4'd3;
    localparam logic [3:0] S_INS_RD = 4'd4;
    localparam logic [3:0] S_INS_WR = 4'd5;
    localparam logic [3:0] S_RM_RD  = 4'd6;
    localparam logic [3:0] S_RM_WR  = 4'd7;
    localparam logic [3:0] S_RES    = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_ctl_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                w_cmd.res_clr    = 1'b1;
                w_cmd.set_status = 1'b1;
                w_cmd.status     = STAT_OK;
                n_state          = S_RES;
                unique case (i_stat.cmd) inside
                    CMD_ADD_FIRST, CMD_ADD_LAST: begin
                        if (i_stat.full) begin
                            w_cmd.status = STAT_FULL;
                        end else begin
                            w_cmd.ins_load = 1'b1;
                            w_cmd.k_sel    = (i_stat.cmd == CMD_ADD_FIRST) ? K_ZERO : K_COUNT;
                            n_state        = S_INS_RD;
                        end
                    end
                    CMD_INSERT: begin
                        if (!i_stat.ins_ok) begin
                            w_cmd.status = STAT_INDEX;
                        end else if (i_stat.full) begin
                            w_cmd.status = STAT_FULL;
                        end else begin
                            w_cmd.ins_load = 1'b1;
                            w_cmd.k_sel    = K_POS_M1;
                            n_state        = S_INS_RD;
                        end
                    end
                    CMD_REMOVE_FIRST, CMD_REMOVE_LAST: begin
                        if (i_stat.empty) begin
                            w_cmd.status = STAT_EMPTY;
                        end else begin
                            w_cmd.idx_load = 1'b1;
                            w_cmd.k_sel    = (i_stat.cmd == CMD_REMOVE_FIRST) ? K_ZERO
                                                                             : K_COUNT_M1;
                            n_state        = S_RD_AT;
                        end
                    end
                    CMD_REMOVE, CMD_SET, CMD_GET: begin
                        if (!i_stat.pos_ok) begin
                            w_cmd.status = STAT_INDEX;
                        end else begin
                            w_cmd.idx_load = 1'b1;
                            w_cmd.k_sel    = K_POS_M1;
                            n_state        = S_RD_AT;
                        end
                    end
                    default: begin
                        n_state = S_RES;
                    end
                endcase
            end
            S_RD_AT: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = RD_IDX;
                n_state      = S_CAP;
            end
            S_CAP: begin
                w_cmd.cap = 1'b1;
                unique case (i_stat.cmd) inside
                    CMD_SET: begin
                        w_cmd.wr_en  = 1'b1;
                        w_cmd.wr_sel = WR_VALUE;
                        n_state      = S_RES;
                    end
                    CMD_GET: begin
                        n_state = S_RES;
                    end
                    default: begin
                        n_state = S_RM_RD;
                    end
                endcase
            end
            S_INS_RD: begin
                if (i_stat.idx_gt_end) begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_IDX_M1;
                    n_state      = S_INS_WR;
                end else begin
                    w_cmd.wr_en   = 1'b1;
                    w_cmd.wr_sel  = WR_VALUE;
                    w_cmd.cnt_inc = 1'b1;
                    n_state       = S_RES;
                end
            end
            S_INS_WR: begin
                w_cmd.wr_en   = 1'b1;
                w_cmd.wr_sel  = WR_RDATA;
                w_cmd.idx_dec = 1'b1;
                n_state       = S_INS_RD;
            end
            S_RM_RD: begin
                if (i_stat.rm_more) begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_IDX_P1;
                    n_state      = S_RM_WR;
                end else begin
                    w_cmd.cnt_dec = 1'b1;
                    n_state       = S_RES;
                end
            end
            S_RM_WR: begin
                w_cmd.wr_en   = 1'b1;
                w_cmd.wr_sel  = WR_RDATA;
                w_cmd.idx_inc = 1'b1;
                n_state       = S_RM_RD;
            end
            S_RES: begin
                if (!i_stat.out_busy) begin
                    w_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

### rtl/core/iolu_checker.sv
// port checker of the indexed ordered list unit and its bind
`include "indexed_ordered_list_unit_macros.svh"

module iolu_checker #(
    parameter int DEPTH = iolu_pkg::DEPTH_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input iolu_pkg::t_out_word o_out_word
);
    import iolu_pkg::*;

    logic w_out_stall;
    logic w_in_take;
    logic w_err_res;
    logic w_empty_res;
    logic w_full_res;
    logic w_cnt_zero;
    logic w_cnt_full;

    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_in_take   = i_in_valid && o_in_ready;
    assign w_err_res   = o_out_valid && (o_out_word.status != STAT_OK);
    assign w_empty_res = o_out_valid && (o_out_word.status == STAT_EMPTY);
    assign w_full_res  = o_out_valid && (o_out_word.status == STAT_FULL);
    assign w_cnt_zero  = o_out_word.empty_flag && (o_out_word.count == '0);
    assign w_cnt_full  = (o_out_word.count == CNT_OUT_W'(DEPTH));

    `IOLU_ASSERT_NXT(a_out_hold, w_out_stall, o_out_valid && $stable(o_out_word), "word not held")
    `IOLU_ASSERT_NXT(a_no_b2b, w_in_take, !o_in_ready, "command word taken back to back")
    `IOLU_ASSERT_IMP(a_err_zero, w_err_res, o_out_word.data_out == '0, "error result carries data")
    `IOLU_ASSERT_IMP(a_empty_st, w_empty_res, w_cnt_zero, "empty error on a nonempty list")
    `IOLU_ASSERT_ALWAYS(a_full_cnt, !w_full_res || w_cnt_full, "full error without a full count")

endmodule

bind indexed_ordered_list_unit iolu_checker #(.DEPTH(DEPTH)) u_iolu_checker (.*);

### tb/tb_top.sv
// self-checking testbench for the indexed ordered list unit: directed cases, then random traffic
`timescale 1ns / 100ps

module tb_top;
    import iolu_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 64;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    logic [VALUE_W-1:0] list_vals [LIST_DEPTH];
    int                 list_len = 0;
    t_out_word          expected_q [$];

    bit tx_idle   = 1'b0;
    bit rx_stalls = 1'b0;
    int hold_cnt  = 0;

    int words_sent      = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;
    int full_rejects    = 0;
    int empty_rejects   = 0;
    int index_rejects   = 0;
    int times_full      = 0;

    indexed_ordered_list_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void list_put(input int slot, input logic [VALUE_W-1:0] val);
        for (int i = list_len; i > slot; i--) list_vals[i] = list_vals[i-1];
        list_vals[slot] = val;
        list_len++;
        if (list_len == LIST_DEPTH) times_full++;
    endfunction

    function automatic logic [VALUE_W-1:0] list_take(input int slot);
        logic [VALUE_W-1:0] old;
        old = list_vals[slot];
        for (int i = slot; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
        list_len--;
        return old;
    endfunction

    // updates the list and returns the result word the command should produce
    function automatic t_out_word apply_command(input t_in_word w);
        t_out_word r;
        int        p;
        bit        full;
        bit        pos_ok;
        r      = '0;
        r.status = STAT_OK;
        p      = int'(w.position);
        full   = (list_len >= LIST_DEPTH);
        pos_ok = (p >= 1) && (p <= list_len);
        case (w.command)
            CMD_ADD_FIRST: begin
                if (full) r.status = STAT_FULL;
                else list_put(0, w.value);
            end
            CMD_ADD_LAST: begin
                if (full) r.status = STAT_FULL;
                else list_put(list_len, w.value);
            end
            CMD_INSERT: begin
                if (p < 1 || p > list_len + 1) r.status = STAT_INDEX;
                else if (full) r.status = STAT_FULL;
                else list_put(p - 1, w.value);
            end
            CMD_REMOVE_FIRST: begin
                if (list_len == 0) r.status = STAT_EMPTY;
                else r.data_out = list_take(0);
            end
            CMD_REMOVE_LAST: begin
                if (list_len == 0) r.status = STAT_EMPTY;
                else r.data_out = list_take(list_len - 1);
            end
            CMD_REMOVE: begin
                if (!pos_ok) r.status = STAT_INDEX;
                else r.data_out = list_take(p - 1);
            end
            CMD_SET: begin
                if (!pos_ok) r.status = STAT_INDEX;
                else begin
                    r.data_out     = list_vals[p-1];
                    list_vals[p-1] = w.value;
                end
            end
            default: begin
                if (!pos_ok) r.status = STAT_INDEX;
                else r.data_out = list_vals[p-1];
            end
        endcase
        case (r.status)
            STAT_FULL:  full_rejects++;
            STAT_EMPTY: empty_rejects++;
            STAT_INDEX: index_rejects++;
            default: ;
        endcase
        r.count      = CNT_OUT_W'(list_len);
        r.empty_flag = (list_len == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at result %0d: %s got 0x%08h expected 0x%08h",
                     results_checked, field, got, want);
    endtask

    task automatic pause_tx(input int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [VALUE_W-1:0] val);
        t_in_word w;
        w.command  = cmd;
        w.position = pos;
        w.value    = val;
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_q.push_back(apply_command(w));
        words_sent++;
        pause_tx(tx_idle ? pick_gap() : 0);
    endtask

    task automatic wait_drained();
        if (expected_q.size() != 0) begin
            in_valid <= 1'b0;
            while (expected_q.size() != 0) @(posedge clk);
        end
    endtask

    task automatic test_empty_errors();
        send_cmd(CMD_REMOVE_FIRST, 5'd1, 32'hFFFF_FFFF);
        send_cmd(CMD_REMOVE_LAST, 5'd0, 32'h0);
        send_cmd(CMD_REMOVE, 5'd1, 32'h0);
        send_cmd(CMD_GET, 5'd0, 32'h0);
        send_cmd(CMD_INSERT, 5'd2, 32'h1234_5678);
    endtask

    task automatic test_fill_to_full();
        logic [VALUE_W-1:0] patterns [7] = '{32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
                                             32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE,
                                             32'h0000_0000};
        logic [VALUE_W-1:0] val;
        send_cmd(CMD_INSERT, 5'd1, 32'h0000_0000);
        send_cmd(CMD_SET, 5'd1, 32'hFFFF_FFFF);
        for (int i = 0; i < LIST_DEPTH - 1; i++) begin
            val = (i < 7) ? patterns[i] : $urandom;
            case (i % 3)
                0: send_cmd(CMD_ADD_FIRST, 5'd0, val);
                1: send_cmd(CMD_ADD_LAST, 5'd31, val);
                default: send_cmd(CMD_INSERT, POS_W'($urandom_range(1, list_len + 1)), val);
            endcase
        end
    endtask

    task automatic test_full_errors();
        send_cmd(CMD_ADD_FIRST, 5'd1, 32'hDEAD_0001);
        send_cmd(CMD_ADD_LAST, 5'd1, 32'hDEAD_0002);
        send_cmd(CMD_INSERT, 5'd17, 32'hDEAD_0003);
        send_cmd(CMD_INSERT, 5'd31, 32'hDEAD_0004);
    endtask

    task automatic test_position_edges();
        send_cmd(CMD_GET, 5'd1, 32'h0);
        send_cmd(CMD_GET, 5'd16, 32'h0);
        send_cmd(CMD_GET, 5'd17, 32'h0);
        send_cmd(CMD_SET, 5'd31, 32'hCAFE_0000);
        send_cmd(CMD_SET, 5'd16, 32'hCAFE_0016);
        send_cmd(CMD_REMOVE, 5'd0, 32'h0);
        send_cmd(CMD_REMOVE, 5'd8, 32'h0);
        send_cmd(CMD_REMOVE_LAST, 5'd0, 32'h0);
        send_cmd(CMD_REMOVE_FIRST, 5'd0, 32'h0);
    endtask

    // mostly legal commands with positions in range, random positions while the list is empty, the rest raw noise
    task automatic send_random(input int grow);
        logic [CMD_W-1:0] adds [3] = '{CMD_ADD_FIRST, CMD_ADD_LAST, CMD_INSERT};
        logic [CMD_W-1:0] rems [3] = '{CMD_REMOVE_FIRST, CMD_REMOVE_LAST, CMD_REMOVE};
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            cmd = CMD_W'($urandom);
            pos = POS_W'($urandom);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < grow) cmd = adds[$urandom_range(0, 2)];
            else if (pick < 70) cmd = rems[$urandom_range(0, 2)];
            else cmd = ($urandom_range(0, 1) != 0) ? CMD_SET : CMD_GET;
            if (cmd == CMD_INSERT) pos = POS_W'($urandom_range(1, list_len + 1));
            else if (list_len == 0) pos = POS_W'($urandom_range(0, 31));
            else pos = POS_W'($urandom_range(1, list_len));
        end
        send_cmd(cmd, pos, $urandom);
    endtask

    task automatic test_random_traffic();
        int grow;
        for (int seg = 0; seg < 16; seg++) begin
            case (seg % 4)
                0: grow = 55;
                1: grow = 35;
                2: grow = 15;
                default: grow = $urandom_range(15, 55);
            endcase
            tx_idle   = (seg % 3 != 0);
            rx_stalls = (seg % 4 != 0);
            for (int n = 0; n < 50; n++) send_random(grow);
            if (seg % 4 == 3) wait_drained();
        end
    endtask

    always @(posedge clk) begin
        if (hold_cnt != 0) hold_cnt--;
        else if (rx_stalls) hold_cnt = pick_gap();
        out_ready <= (hold_cnt == 0);
    end

    always @(posedge clk) begin : result_check
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", out_word.data_out, '0);
            end else begin
                want = expected_q.pop_front();
                if (out_word.data_out !== want.data_out)
                    report_mismatch("data_out", out_word.data_out, want.data_out);
                if (out_word.status !== want.status)
                    report_mismatch("status", 32'(out_word.status), 32'(want.status));
                if (out_word.count !== want.count)
                    report_mismatch("count", 32'(out_word.count), 32'(want.count));
                if (out_word.empty_flag !== want.empty_flag)
                    report_mismatch("empty_flag", 32'(out_word.empty_flag),
                                    32'(want.empty_flag));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle   = 1'b1;
        rx_stalls = 1'b1;
        test_empty_errors();
        test_fill_to_full();
        test_full_errors();
        wait_drained();
        test_position_edges();
        test_random_traffic();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("sent %0d commands, checked %0d results, list reached full %0d times",
                 words_sent, results_checked, times_full);
        $display("rejections seen: %0d full, %0d empty, %0d bad position",
                 full_rejects, empty_rejects, index_rejects);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
